FILE: src/query_key_value_lookup_assert.svh
// assertion macros used by the query key lookup datapath
// include guard only, no other dependencies
`ifndef QUERY_KEY_VALUE_LOOKUP_ASSERT_SVH
`define QUERY_KEY_VALUE_LOOKUP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define QKVL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define QKVL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/qkvl_pkg.sv
// shared types and constants for the query key lookup block
// no dependencies
`default_nettype none

package qkvl_pkg;

    localparam int KEY_MAX_DEF   = 8;
    localparam int VALUE_MAX_DEF = 63;

    localparam int KEY_W   = 64;
    localparam int KLEN_W  = 4;
    localparam int CAP_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int VLEN_W  = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
    localparam logic [BYTE_W-1:0] CH_AMP = 8'h26;
    localparam logic [BYTE_W-1:0] CH_EQ  = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_BYTES  = 2'd0,
        REG_KEY_LENGTH = 2'd1,
        REG_VALUE_CAP  = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_NOT_FOUND = 2'd0,
        ST_FOUND     = 2'd1,
        ST_TOO_LONG  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_RUN,
        S_FETCH,
        S_BYTE,
        S_STATUS
    } t_state;

    typedef struct packed {
        logic take;
        logic rd_issue;
        logic load_byte;
        logic load_status;
    } t_dp_cmd;

    typedef struct packed {
        logic item_last;
        logic has_bytes;
        logic last_byte;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: src/qkvl_ctrl.sv
// controller state machine: input phase and result burst sequencing
// depends on qkvl_pkg
`default_nettype none

module qkvl_ctrl
    import qkvl_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RUN: begin
                if (i_in_valid && i_sts.item_last) begin
                    n_state = i_sts.has_bytes ? S_FETCH : S_STATUS;
                end
            end
            S_FETCH: begin
                n_state = S_BYTE;
            end
            S_BYTE: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.last_byte ? S_STATUS : S_FETCH;
                end
            end
            S_STATUS: begin
                if (i_sts.out_free) begin
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_comb begin
        o_in_stall        = 1'b1;
        o_cmd.take        = 1'b0;
        o_cmd.rd_issue    = 1'b0;
        o_cmd.load_byte   = 1'b0;
        o_cmd.load_status = 1'b0;
        case (r_state)
            S_RUN: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_in_valid;
            end
            S_FETCH: begin
                o_cmd.rd_issue = 1'b1;
            end
            S_BYTE: begin
                o_cmd.load_byte = i_sts.out_free;
            end
            S_STATUS: begin
                o_cmd.load_status = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/qkvl_datapath.sv
// datapath: config registers, segment parser, value buffer, output register
// depends on qkvl_pkg and query_key_value_lookup_assert.svh
`default_nettype none

`include "query_key_value_lookup_assert.svh"

module qkvl_datapath
    import qkvl_pkg::*;
#(
    parameter int KEY_MAX   = KEY_MAX_DEF,
    parameter int VALUE_MAX = VALUE_MAX_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_valid,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [KEY_W-1:0]       i_cfg_data,
    output logic                   o_cfg_ready,
    input  wire  [BYTE_W-1:0]      i_query_byte,
    input  wire                    i_has_byte,
    input  wire                    i_end_of_query,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  wire                    i_out_stall,
    output logic                   o_out_valid,
    output logic [BYTE_W-1:0]      o_value_byte,
    output logic                   o_is_status,
    output logic [1:0]             o_lookup_status,
    output logic [VLEN_W-1:0]      o_value_length,
    output logic                   o_last_result
);

    localparam int PW     = $clog2(KEY_MAX + 1);
    localparam int CNT_W  = $clog2(VALUE_MAX + 2);
    localparam int LEN_W  = $clog2(VALUE_MAX + 1);
    localparam int AW     = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;
    localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(VALUE_MAX + 1);

    // configuration
    logic [KEY_W-1:0]  r_key_bytes;
    logic [KLEN_W-1:0] r_key_length;
    logic [CAP_W-1:0]  r_value_cap;

    // run state
    logic [PW-1:0]     r_pos;
    logic              r_prefix_ok;
    logic              r_in_value;
    logic [CNT_W-1:0]  r_count;
    logic              r_decided;
    t_status           r_dec_status;

    logic [PW-1:0]     n_pos;
    logic              n_prefix_ok;
    logic              n_in_value;
    logic [CNT_W-1:0]  n_count;
    logic              n_decided;
    t_status           n_dec_status;

    // result burst
    t_status           r_fin_status;
    logic [LEN_W-1:0]  r_fin_len;
    logic [LEN_W-1:0]  r_rd_idx;
    logic [BYTE_W-1:0] r_rd_data;
    logic [BYTE_W-1:0] r_mem [VALUE_MAX];

    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_valid;
    logic              r_out_is_status;
    t_status           r_out_status;
    logic [LEN_W-1:0]  r_out_len;

    logic              disabled;
    logic [CAP_W-1:0]  eff_cap;
    logic              process;
    logic              is_sep;
    logic [BYTE_W-1:0] key_char;
    logic [CNT_W-1:0]  count_inc;
    logic              mem_we;
    t_status           fin_status;
    logic [LEN_W-1:0]  fin_len;
    logic              out_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes  <= '0;
            r_key_length <= '0;
            r_value_cap  <= CAP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KEY_BYTES:  r_key_bytes  <= i_cfg_data;
                REG_KEY_LENGTH: r_key_length <= i_cfg_data[KLEN_W-1:0];
                REG_VALUE_CAP:  r_value_cap  <= i_cfg_data[CAP_W-1:0];
                default:        r_key_bytes  <= r_key_bytes;
            endcase
        end
    end

    assign disabled = (r_key_length == '0) || (r_key_length > KLEN_W'(KEY_MAX))
                      || (r_value_cap == '0);
    assign eff_cap  = (r_value_cap > CAP_LIMIT) ? CAP_LIMIT : r_value_cap;
    assign process  = i_cmd.take && i_has_byte && !r_decided && !disabled;
    assign is_sep   = (i_query_byte == CH_AMP) || (i_query_byte == CH_NUL);
    assign key_char = r_key_bytes[BYTE_W*(3'(r_pos)) +: BYTE_W];
    assign count_inc = r_count + CNT_W'(1);

    // one byte of the segment parser
    always_comb begin
        n_pos        = r_pos;
        n_prefix_ok  = r_prefix_ok;
        n_in_value   = r_in_value;
        n_count      = r_count;
        n_decided    = r_decided;
        n_dec_status = r_dec_status;
        mem_we       = 1'b0;
        if (process) begin
            if (is_sep) begin
                if (r_in_value) begin
                    n_decided    = 1'b1;
                    n_dec_status = ST_FOUND;
                end else begin
                    n_pos       = '0;
                    n_prefix_ok = 1'b1;
                    if (i_query_byte == CH_NUL) begin
                        n_decided    = 1'b1;
                        n_dec_status = ST_NOT_FOUND;
                    end
                end
            end else if (r_in_value) begin
                mem_we  = (r_count < CNT_W'(VALUE_MAX));
                n_count = count_inc;
                if (CAP_W'(count_inc) >= eff_cap) begin
                    n_decided    = 1'b1;
                    n_dec_status = ST_TOO_LONG;
                end
            end else if (r_prefix_ok) begin
                if (KLEN_W'(r_pos) < r_key_length) begin
                    if (key_char != i_query_byte) begin
                        n_prefix_ok = 1'b0;
                    end else begin
                        n_pos = r_pos + PW'(1);
                    end
                end else if (i_query_byte == CH_EQ) begin
                    n_in_value = 1'b1;
                    n_count    = '0;
                end else begin
                    n_prefix_ok = 1'b0;
                end
            end
        end
    end

    // closing decision for the item that ends the query
    always_comb begin
        if (disabled) begin
            fin_status = ST_NOT_FOUND;
        end else if (n_decided) begin
            fin_status = n_dec_status;
        end else if (n_in_value) begin
            fin_status = ST_FOUND;
        end else begin
            fin_status = ST_NOT_FOUND;
        end
        if (fin_status != ST_FOUND) begin
            fin_len = '0;
        end else if (n_count > CNT_W'(VALUE_MAX)) begin
            fin_len = LEN_W'(VALUE_MAX);
        end else begin
            fin_len = LEN_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_prefix_ok  <= 1'b1;
            r_in_value   <= 1'b0;
            r_count      <= '0;
            r_decided    <= 1'b0;
            r_dec_status <= ST_NOT_FOUND;
        end else if (i_cmd.take && i_end_of_query) begin
            r_pos        <= '0;
            r_prefix_ok  <= 1'b1;
            r_in_value   <= 1'b0;
            r_count      <= '0;
            r_decided    <= 1'b0;
            r_dec_status <= ST_NOT_FOUND;
        end else begin
            r_pos        <= n_pos;
            r_prefix_ok  <= n_prefix_ok;
            r_in_value   <= n_in_value;
            r_count      <= n_count;
            r_decided    <= n_decided;
            r_dec_status <= n_dec_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_status <= ST_NOT_FOUND;
            r_fin_len    <= '0;
            r_rd_idx     <= '0;
        end else if (i_cmd.take && i_end_of_query) begin
            r_fin_status <= fin_status;
            r_fin_len    <= fin_len;
            r_rd_idx     <= '0;
        end else if (i_cmd.load_byte) begin
            r_rd_idx <= r_rd_idx + LEN_W'(1);
        end
    end

    // value buffer
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[AW'(r_count)] <= i_query_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[AW'(r_rd_idx)];
        end
    end

    // output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_byte || i_cmd.load_status) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_out_byte      <= r_rd_data;
            r_out_is_status <= 1'b0;
            r_out_status    <= ST_NOT_FOUND;
            r_out_len       <= '0;
        end else if (i_cmd.load_status) begin
            r_out_byte      <= '0;
            r_out_is_status <= 1'b1;
            r_out_status    <= r_fin_status;
            r_out_len       <= r_fin_len;
        end
    end

    assign o_sts.item_last = i_end_of_query;
    assign o_sts.has_bytes = (fin_len != '0);
    assign o_sts.last_byte = ((r_rd_idx + LEN_W'(1)) == r_fin_len);
    assign o_sts.out_free  = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_value_byte    = r_out_byte;
    assign o_is_status     = r_out_is_status;
    assign o_lookup_status = r_out_status;
    assign o_value_length  = VLEN_W'(r_out_len);
    assign o_last_result   = r_out_is_status;

    `QKVL_ASSERT_NOW(a_load_needs_room, i_clk, i_rst_n,
        i_cmd.load_byte || i_cmd.load_status, out_free, "output register overwritten")
    `QKVL_ASSERT_NOW(a_read_in_range, i_clk, i_rst_n,
        i_cmd.load_byte, r_rd_idx < r_fin_len, "value read past its length")
    `QKVL_ASSERT_NEXT(a_status_shown, i_clk, i_rst_n,
        i_cmd.load_status, r_out_valid && r_out_is_status, "status request not presented")

endmodule

`default_nettype wire

FILE: src/query_key_value_lookup.sv
// Query string key lookup, top level.
// Input channel: one query byte per request (i_in_valid / o_in_stall), with
// has_byte low for a request with no byte and end_of_query on the last one.
// Config channel: i_cfg_valid / o_cfg_ready with a register index and data
// (0 key bytes, 1 key length, 2 value capacity); write only while idle.
// Output channel: o_out_valid / i_out_stall; value bytes then one status
// request marked by is_status and last_result.
// Throughput: one input request per cycle while a query streams in. After the
// final request the input stalls while the value buffer is read out: each
// value byte is first read from the buffer into a register (S_FETCH), then
// loaded into the output register (S_BYTE); the status request is loaded
// last (S_STATUS), straight after the final request when the value is empty.
// A stalled output holds its request; the burst waits on the output register.
// Reset (synchronous, active low) clears the search state and the config to
// key length 0 and capacity 64; the value buffer is not cleared.
// depends on qkvl_pkg, qkvl_ctrl, qkvl_datapath
`default_nettype none

module query_key_value_lookup
    import qkvl_pkg::*;
#(
    parameter int KEY_MAX   = KEY_MAX_DEF,
    parameter int VALUE_MAX = VALUE_MAX_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    input  wire  [CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [KEY_W-1:0]     i_cfg_data,
    output logic                 o_cfg_ready,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire  [BYTE_W-1:0]    i_query_byte,
    input  wire                  i_has_byte,
    input  wire                  i_end_of_query,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic [BYTE_W-1:0]    o_value_byte,
    output logic                 o_is_status,
    output logic [1:0]           o_lookup_status,
    output logic [VLEN_W-1:0]    o_value_length,
    output logic                 o_last_result
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    qkvl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    qkvl_datapath #(
        .KEY_MAX   (KEY_MAX),
        .VALUE_MAX (VALUE_MAX)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_cfg_ready     (o_cfg_ready),
        .i_query_byte    (i_query_byte),
        .i_has_byte      (i_has_byte),
        .i_end_of_query  (i_end_of_query),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_value_byte    (o_value_byte),
        .o_is_status     (o_is_status),
        .o_lookup_status (o_lookup_status),
        .o_value_length  (o_value_length),
        .o_last_result   (o_last_result)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// self-checking bench for query_key_value_lookup: streams query strings in,
// predicts the value bytes and closing status, and compares every result
// depends on qkvl_pkg and the query_key_value_lookup rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import qkvl_pkg::*;

    localparam int IDLE_LIMIT = 3000;

    typedef logic [BYTE_W-1:0] t_byte_q[$];

    typedef struct packed {
        logic [BYTE_W-1:0] value_byte;
        logic              is_status;
        t_status           status;
        logic [VLEN_W-1:0] value_length;
        logic              last_result;
    } t_lookup_item;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [KEY_W-1:0]     i_cfg_data;
    logic                 o_cfg_ready;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_query_byte;
    logic                 i_has_byte;
    logic                 i_end_of_query;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [BYTE_W-1:0]    o_value_byte;
    logic                 o_is_status;
    logic [1:0]           o_lookup_status;
    logic [VLEN_W-1:0]    o_value_length;
    logic                 o_last_result;

    // mirror of the lookup registers and search state
    logic [KEY_W-1:0]  key_reg;
    logic [KLEN_W-1:0] klen_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [3:0]        seg_pos;
    logic              prefix_ok;
    logic              in_val;
    logic [6:0]        vcount;
    logic              decided;
    t_status           decided_st;
    logic [BYTE_W-1:0] vstore [VALUE_MAX_DEF];

    t_lookup_item awaited_q[$];
    t_lookup_item want;
    int  mismatch_count = 0;
    int  idle_cycles = 0;
    int  items_sent = 0;
    int  gap_rate;
    bit  calm;

    query_key_value_lookup i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_query_byte   (i_query_byte),
        .i_has_byte     (i_has_byte),
        .i_end_of_query (i_end_of_query),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_value_byte   (o_value_byte),
        .o_is_status    (o_is_status),
        .o_lookup_status(o_lookup_status),
        .o_value_length (o_value_length),
        .o_last_result  (o_last_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic lookup_off();
        return klen_reg == 0 || klen_reg > KEY_MAX_DEF || cap_reg == 0;
    endfunction

    function automatic void clear_search_state();
        seg_pos    = '0;
        prefix_ok  = 1'b1;
        in_val     = 1'b0;
        vcount     = '0;
        decided    = 1'b0;
        decided_st = ST_NOT_FOUND;
    endfunction

    task automatic scan_query_byte(input logic [BYTE_W-1:0] b);
        logic [CAP_W-1:0] cap_eff;
        cap_eff = (cap_reg > VALUE_MAX_DEF + 1) ? CAP_W'(VALUE_MAX_DEF + 1) : cap_reg;
        if (b == CH_AMP || b == CH_NUL) begin
            if (in_val) begin
                decided    = 1'b1;
                decided_st = ST_FOUND;
            end else begin
                seg_pos   = '0;
                prefix_ok = 1'b1;
                if (b == CH_NUL) begin
                    decided    = 1'b1;
                    decided_st = ST_NOT_FOUND;
                end
            end
        end else if (in_val) begin
            if (vcount < VALUE_MAX_DEF)
                vstore[vcount] = b;
            vcount++;
            if (vcount >= cap_eff) begin
                decided    = 1'b1;
                decided_st = ST_TOO_LONG;
            end
        end else if (prefix_ok) begin
            if (seg_pos < klen_reg) begin
                if (key_reg[seg_pos[2:0]*8 +: 8] != b)
                    prefix_ok = 1'b0;
                else
                    seg_pos++;
            end else if (b == CH_EQ) begin
                in_val = 1'b1;
                vcount = '0;
            end else begin
                prefix_ok = 1'b0;
            end
        end
    endtask

    // value bytes and the closing status for one accepted request
    task automatic predict_lookup(input logic [BYTE_W-1:0] b, input logic has,
                                  input logic last);
        t_status      st;
        int           nvals;
        t_lookup_item r;
        if (has && !decided && !lookup_off())
            scan_query_byte(b);
        if (last) begin
            if (lookup_off())
                st = ST_NOT_FOUND;
            else if (decided)
                st = decided_st;
            else
                st = in_val ? ST_FOUND : ST_NOT_FOUND;
            nvals = 0;
            if (st == ST_FOUND) begin
                nvals = (vcount > VALUE_MAX_DEF) ? VALUE_MAX_DEF : vcount;
                for (int k = 0; k < nvals; k++) begin
                    r = '0;
                    r.value_byte = vstore[k];
                    awaited_q.push_back(r);
                end
            end
            r = '0;
            r.is_status    = 1'b1;
            r.status       = st;
            r.value_length = (st == ST_FOUND) ? VLEN_W'(nvals) : '0;
            r.last_result  = 1'b1;
            awaited_q.push_back(r);
            clear_search_state();
        end
    endtask

    function automatic t_byte_q text_bytes(input string s);
        t_byte_q q;
        for (int k = 0; k < s.len(); k++)
            q.push_back(s[k]);
        return q;
    endfunction

    function automatic logic [KEY_W-1:0] pack_key(input string s);
        logic [KEY_W-1:0] v;
        v = '0;
        for (int k = 0; k < s.len() && k < 8; k++)
            v[k*8 +: 8] = s[k];
        return v;
    endfunction

    // mostly well-formed segments built around the current key
    function automatic t_byte_q random_query();
        t_byte_q     q;
        int          nseg, kind, klen, vlen, cut, eff_cap;
        logic [BYTE_W-1:0] vb;
        klen = (klen_reg > KEY_MAX_DEF) ? KEY_MAX_DEF : klen_reg;
        if (cap_reg == 0)
            eff_cap = 4;
        else
            eff_cap = (cap_reg > VALUE_MAX_DEF + 1) ? VALUE_MAX_DEF + 1 : cap_reg;
        if ($urandom_range(0, 24) == 0)
            return q;
        nseg = $urandom_range(1, 3);
        for (int s = 0; s < nseg; s++) begin
            if (s != 0)
                q.push_back(CH_AMP);
            kind = $urandom_range(0, 11);
            vlen = $urandom_range(0, 6);
            if (kind <= 6) begin
                cut = (kind == 4) ? $urandom_range(0, klen) : klen;
                for (int k = 0; k < cut; k++)
                    q.push_back(key_reg[k*8 +: 8]);
                if (kind == 4 || kind == 5) begin
                    vb = BYTE_W'($urandom_range(1, 255));
                    q.push_back(vb == CH_AMP ? 8'h61 : vb);
                end
                q.push_back(CH_EQ);
                if (kind == 6)
                    vlen = eff_cap - 1 + $urandom_range(0, 2);
            end
            for (int k = 0; k < vlen; k++) begin
                vb = BYTE_W'($urandom_range(1, 255));
                q.push_back(vb == CH_AMP ? 8'h61 : vb);
            end
            if ($urandom_range(0, 24) == 0)
                q.push_back(CH_NUL);
        end
        return q;
    endfunction

    // one input request; leaves valid high so a following request follows directly
    task automatic send_item(input logic [BYTE_W-1:0] b, input logic has, input logic last);
        if (!calm && $urandom_range(0, 9) < gap_rate) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_query_byte   = b;
        i_has_byte     = has;
        i_end_of_query = last;
        i_in_valid     = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_lookup(b, has, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_query(input t_byte_q q, input int blank_pct);
        logic tail_blank;
        tail_blank = (q.size() == 0) || ($urandom_range(0, 99) < blank_pct);
        foreach (q[k]) begin
            if ($urandom_range(0, 99) < blank_pct)
                send_item(BYTE_W'($urandom), 1'b0, 1'b0);
            send_item(q[k], 1'b1, !tail_blank && k == q.size() - 1);
        end
        if (tail_blank)
            send_item(BYTE_W'($urandom), 1'b0, 1'b1);
        i_in_valid = 1'b0;
    endtask

    // register writes wait until the block has drained its results
    task automatic write_register(input t_cfg_reg idx, input logic [KEY_W-1:0] data);
        i_in_valid = 1'b0;
        while (awaited_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_KEY_BYTES:  key_reg  = data;
            REG_KEY_LENGTH: klen_reg = data[KLEN_W-1:0];
            REG_VALUE_CAP:  cap_reg  = data[CAP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_empty_after_reset();
        send_query(text_bytes(""), 0);
    endtask

    task automatic test_basic_match();
        write_register(REG_KEY_BYTES, pack_key("k"));
        write_register(REG_KEY_LENGTH, 64'd1);
        write_register(REG_VALUE_CAP, 64'd64);
        send_item("k", 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item("=", 1'b1, 1'b0);
        send_item("v", 1'b1, 1'b1);
        send_query(text_bytes("k="), 0);
    endtask

    task automatic test_segments();
        send_query(text_bytes("&k=1&k="), 0);
    endtask

    task automatic test_zero_byte();
        t_byte_q q;
        q = text_bytes("k=a");
        q.push_back(CH_NUL);
        q.push_back("k");
        send_query(q, 0);
    endtask

    task automatic test_mid_query_config();
        write_register(REG_KEY_BYTES, pack_key("kx"));
        send_item("k", 1'b1, 1'b0);
        write_register(REG_KEY_LENGTH, 64'd2);
        send_query(text_bytes("x=7"), 0);
    endtask

    task automatic test_too_long();
        write_register(REG_KEY_LENGTH, 64'd1);
        write_register(REG_VALUE_CAP, 64'd1);
        send_query(text_bytes("k=a&k="), 0);
    endtask

    task automatic test_disabled_key();
        write_register(REG_KEY_LENGTH, 64'd9);
        write_register(REG_VALUE_CAP, 64'd64);
        send_query(text_bytes("k="), 0);
        write_register(REG_KEY_LENGTH, 64'd1);
        write_register(REG_VALUE_CAP, 64'd0);
        send_query(text_bytes("k="), 0);
    endtask

    task automatic test_amp_key();
        write_register(REG_KEY_BYTES, pack_key("&"));
        write_register(REG_VALUE_CAP, 64'd64);
        send_query(text_bytes("&=1"), 0);
    endtask

    task automatic test_random_lookups();
        int klen, cap, stop_at, r;
        logic [KEY_W-1:0] key;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin klen = 8; cap = 64; end
                1: begin klen = 1; cap = 127; end
                2: begin klen = $urandom_range(1, 8); cap = $urandom_range(1, 8); end
                3: begin klen = $urandom_range(9, 15); cap = $urandom_range(1, 127); end
                4: begin klen = $urandom_range(2, 5); cap = 63; end
                5: begin klen = $urandom_range(1, 8); cap = $urandom_range(65, 126); end
                default: begin klen = $urandom_range(1, 8); cap = $urandom_range(2, 64); end
            endcase
            for (int k = 0; k < 8; k++) begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    key[k*8 +: 8] = CH_AMP;
                else if (r <= 2)
                    key[k*8 +: 8] = BYTE_W'($urandom_range(128, 255));
                else
                    key[k*8 +: 8] = BYTE_W'($urandom_range(33, 126));
                if (r != 0 && key[k*8 +: 8] == CH_AMP)
                    key[k*8 +: 8] = 8'h4B;
            end
            write_register(REG_KEY_BYTES, key);
            write_register(REG_KEY_LENGTH, KEY_W'(klen));
            write_register(REG_VALUE_CAP, KEY_W'(cap));
            // final phase runs back to back on both sides
            calm = (ph == 6);
            stop_at = items_sent + ((ph == 3) ? 4 : 8);
            while (items_sent < stop_at) begin
                gap_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                send_query(random_query(), 6);
            end
        end
    endtask

    // output stall bursts, with stretches of no stalling
    initial begin
        int stretch;
        int rate;
        i_out_stall = 1'b0;
        stretch = 0;
        rate = 0;
        forever begin
            @(negedge i_clk);
            if (stretch == 0) begin
                stretch = $urandom_range(20, 60);
                rate = $urandom_range(0, 2) * 2;
            end
            stretch--;
            if (!calm && $urandom_range(0, 9) < rate) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: byte %h flag %b status %0d len %0d last %b",
                             o_value_byte, o_is_status, o_lookup_status, o_value_length,
                             o_last_result);
            end else begin
                want = awaited_q.pop_front();
                if (want.value_byte !== o_value_byte || want.is_status !== o_is_status ||
                    want.status !== o_lookup_status || want.value_length !== o_value_length ||
                    want.last_result !== o_last_result) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: want byte %h flag %b status %0d len %0d last %b;",
                                 want.value_byte, want.is_status, want.status,
                                 want.value_length, want.last_result,
                                 " got byte %h flag %b status %0d len %0d last %b",
                                 o_value_byte, o_is_status, o_lookup_status,
                                 o_value_length, o_last_result);
                end
            end
        end
    end

    // watchdog on cycles with no request accepted anywhere
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_query_byte   = '0;
        i_has_byte     = 1'b0;
        i_end_of_query = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = REG_KEY_BYTES;
        i_cfg_data     = '0;
        calm           = 1'b0;
        gap_rate       = 3;
        key_reg        = '0;
        klen_reg       = '0;
        cap_reg        = CAP_RESET;
        clear_search_state();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_after_reset();
        test_basic_match();
        test_segments();
        test_zero_byte();
        test_mid_query_config();
        test_too_long();
        test_disabled_key();
        test_amp_key();
        test_random_lookups();

        i_in_valid = 1'b0;
        while (awaited_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0 && awaited_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/qkvl_pkg.sv
src/qkvl_ctrl.sv
src/qkvl_datapath.sv
src/query_key_value_lookup.sv
tb/tb_top.sv
